// ----- hdl/fprc_pkg.sv -----
// Shared types, codes and the CRC-32 byte update for the firmware page receiver.
`default_nettype none

package fprc_pkg;

    // input item modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_STORE  = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_ACK    = 2'd2;
    localparam logic [1:0] KIND_NAK    = 2'd3;

    // packet size selector
    localparam logic [1:0] SEL_LARGE   = 2'd0;
    localparam logic [1:0] SEL_SMALL   = 2'd1;
    localparam logic [1:0] SEL_INVALID = 2'd2;

    localparam logic [7:0] PKT_KIND_LARGE = 8'd0;
    localparam logic [7:0] PKT_KIND_SMALL = 8'd1;

    localparam int          BYTE_CNT_W  = 10;
    localparam logic [10:0] LARGE_SIZE  = 11'd1024;
    localparam logic [10:0] SMALL_SIZE  = 11'd128;
    localparam int          LARGE_SHIFT = 10;
    localparam int          SMALL_SHIFT = 7;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // one decoded item, worth up to three results
    typedef struct packed {
        logic        has_store;
        logic [31:0] store_addr;
        logic [7:0]  data;
        logic        has_commit;
        logic [31:0] commit_addr;
        logic        has_tail;
        logic        tail_nak;
        logic        tail_ok;
    } job_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fprc_front.sv -----
// Front part: accepts items, keeps transfer state and CRC, decodes each item into a job.
`default_nettype none

module fprc_front #(
    parameter int PAGE_BYTES = 2048
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [31:0]   cfg_wr_data,
    input  wire logic          in_valid,
    input  wire logic          in_ready,
    input  wire logic [1:0]    mode,
    input  wire logic [7:0]    packet_kind,
    input  wire logic [7:0]    data_byte,
    input  wire logic [31:0]   sender_crc,
    input  wire logic          crc_present,
    output logic               push,
    output fprc_pkg::job_t     job
);

    localparam int FULL_L_RAW = PAGE_BYTES / 1024;
    localparam int FULL_S_RAW = PAGE_BYTES / 128;
    localparam int FULL_L     = (FULL_L_RAW < 1) ? 1 : FULL_L_RAW;
    localparam int FULL_S     = (FULL_S_RAW < 1) ? 1 : FULL_S_RAW;
    localparam int PKT_W      = $clog2(FULL_S + 1);

    logic [31:0]                       base_reg, base_next;
    logic [31:0]                       crc_reg, crc_next;
    logic [1:0]                        sel_reg, sel_next;
    logic [fprc_pkg::BYTE_CNT_W-1:0]   bytes_reg, bytes_next;
    logic [PKT_W-1:0]                  pkts_reg, pkts_next;
    logic [31:0]                       page_reg, page_next;
    logic [31:0]                       held_reg, held_next;

    logic                              accept;
    logic                              is_large;
    logic [31:0]                       offset;
    logic [fprc_pkg::BYTE_CNT_W:0]     bytes_inc;
    logic [PKT_W-1:0]                  pkts_inc;
    logic [PKT_W-1:0]                  full;
    logic                              pkt_done;
    logic                              page_full;
    logic [31:0]                       fin;
    logic                              match;

    assign accept    = in_valid && in_ready;
    assign is_large  = (sel_reg == fprc_pkg::SEL_LARGE);
    assign offset    = is_large ? (32'(pkts_reg) << fprc_pkg::LARGE_SHIFT)
                                : (32'(pkts_reg) << fprc_pkg::SMALL_SHIFT);
    assign bytes_inc = {1'b0, bytes_reg} + 11'd1;
    assign pkts_inc  = pkts_reg + 1'b1;
    assign full      = is_large ? PKT_W'(FULL_L) : PKT_W'(FULL_S);
    assign pkt_done  = is_large ? (bytes_inc >= fprc_pkg::LARGE_SIZE)
                                : (bytes_inc >= fprc_pkg::SMALL_SIZE);
    assign page_full = (pkts_inc >= full);
    assign fin       = crc_reg ^ fprc_pkg::CRC_INIT;
    assign match     = (fin == (crc_present ? sender_crc : held_reg));

    always_comb
    begin
        base_next  = cfg_wr_en ? cfg_wr_data : base_reg;
        crc_next   = crc_reg;
        sel_next   = sel_reg;
        bytes_next = bytes_reg;
        pkts_next  = pkts_reg;
        page_next  = page_reg;
        held_next  = held_reg;
        push       = 1'b0;
        job        = '0;
        if (accept)
        begin
            case (mode)
                fprc_pkg::MODE_START:
                begin
                    if (packet_kind == fprc_pkg::PKT_KIND_LARGE)
                        sel_next = fprc_pkg::SEL_LARGE;
                    else if (packet_kind == fprc_pkg::PKT_KIND_SMALL)
                        sel_next = fprc_pkg::SEL_SMALL;
                    else
                        sel_next = fprc_pkg::SEL_INVALID;
                    crc_next     = fprc_pkg::CRC_INIT;
                    bytes_next   = '0;
                    push         = 1'b1;
                    job.has_tail = 1'b1;
                end
                fprc_pkg::MODE_DATA:
                begin
                    if (sel_reg == fprc_pkg::SEL_LARGE || sel_reg == fprc_pkg::SEL_SMALL)
                    begin
                        push           = 1'b1;
                        job.has_store  = 1'b1;
                        job.store_addr = page_reg + offset + 32'(bytes_reg);
                        job.data       = data_byte;
                        crc_next       = fprc_pkg::crc_byte(crc_reg, data_byte);
                        if (pkt_done)
                        begin
                            bytes_next   = '0;
                            job.has_tail = 1'b1;
                            if (page_full)
                            begin
                                job.has_commit  = 1'b1;
                                job.commit_addr = page_reg;
                                page_next       = page_reg + 32'(PAGE_BYTES);
                                pkts_next       = '0;
                            end
                            else
                            begin
                                pkts_next = pkts_inc;
                            end
                        end
                        else
                        begin
                            bytes_next = bytes_inc[fprc_pkg::BYTE_CNT_W-1:0];
                        end
                    end
                end
                fprc_pkg::MODE_END:
                begin
                    if (crc_present)
                        held_next = sender_crc;
                    push            = 1'b1;
                    job.has_commit  = (pkts_reg != '0) || (bytes_reg != '0);
                    job.commit_addr = page_reg;
                    job.has_tail    = 1'b1;
                    job.tail_nak    = !match;
                    job.tail_ok     = match;
                    pkts_next       = '0;
                    bytes_next      = '0;
                    page_next       = base_reg;
                    if (match)
                        crc_next = fin;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            crc_reg   <= fprc_pkg::CRC_INIT;
            sel_reg   <= fprc_pkg::SEL_INVALID;
            bytes_reg <= '0;
            pkts_reg  <= '0;
            page_reg  <= '0;
            held_reg  <= '0;
        end
        else
        begin
            base_reg  <= base_next;
            crc_reg   <= crc_next;
            sel_reg   <= sel_next;
            bytes_reg <= bytes_next;
            pkts_reg  <= pkts_next;
            page_reg  <= page_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fprc_queue.sv -----
// Short job queue between the front and back parts.
`default_nettype none

module fprc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire fprc_pkg::job_t push_job,
    output logic                not_full,
    input  wire logic           pop,
    output logic                head_valid,
    output fprc_pkg::job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fprc_pkg::job_t   slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign not_full   = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots[rd_ptr_reg];
    assign do_push    = push && not_full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fprc_back.sv -----
// Back part: expands each queued job into results in the output register, one per cycle unless the output stalls.
`default_nettype none

module fprc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire fprc_pkg::job_t q_job,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          out_kind,
    output logic [31:0]         out_addr,
    output logic [7:0]          out_byte,
    output logic                out_ok,
    output logic                out_last
);

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_addr_reg;
    logic [7:0]  out_byte_reg;
    logic        out_ok_reg;
    logic        out_last_reg;
    logic        store_done_reg, store_done_next;
    logic        commit_done_reg, commit_done_next;

    logic        load;
    logic        pick_store;
    logic        pick_commit;
    logic [1:0]  cur_kind;
    logic [31:0] cur_addr;
    logic [7:0]  cur_byte;
    logic        cur_ok;
    logic        cur_last;

    assign load = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        pick_store  = q_job.has_store && !store_done_reg;
        pick_commit = !pick_store && q_job.has_commit && !commit_done_reg;
        if (pick_store)
        begin
            cur_kind = fprc_pkg::KIND_STORE;
            cur_addr = q_job.store_addr;
            cur_byte = q_job.data;
            cur_ok   = 1'b0;
            cur_last = !(q_job.has_commit || q_job.has_tail);
        end
        else if (pick_commit)
        begin
            cur_kind = fprc_pkg::KIND_COMMIT;
            cur_addr = q_job.commit_addr;
            cur_byte = '0;
            cur_ok   = 1'b0;
            cur_last = !q_job.has_tail;
        end
        else
        begin
            cur_kind = q_job.tail_nak ? fprc_pkg::KIND_NAK : fprc_pkg::KIND_ACK;
            cur_addr = '0;
            cur_byte = '0;
            cur_ok   = q_job.tail_ok;
            cur_last = 1'b1;
        end
    end

    always_comb
    begin
        q_pop            = load && cur_last;
        store_done_next  = store_done_reg;
        commit_done_next = commit_done_reg;
        if (load)
        begin
            if (cur_last)
            begin
                store_done_next  = 1'b0;
                commit_done_next = 1'b0;
            end
            else if (pick_store)
                store_done_next = 1'b1;
            else
                commit_done_next = 1'b1;
        end
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            store_done_reg  <= 1'b0;
            commit_done_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            store_done_reg  <= store_done_next;
            commit_done_reg <= commit_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg <= cur_kind;
            out_addr_reg <= cur_addr;
            out_byte_reg <= cur_byte;
            out_ok_reg   <= cur_ok;
            out_last_reg <= cur_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_addr  = out_addr_reg;
    assign out_byte  = out_byte_reg;
    assign out_ok    = out_ok_reg;
    assign out_last  = out_last_reg;

    // a part-done job must still sit at the head
    a_store_done_head: assert property (@(posedge clk) disable iff (!rst_n)
        store_done_reg |-> (q_valid && q_job.has_store))
        else $error("store marked done with no matching head job");

    a_commit_done_head: assert property (@(posedge clk) disable iff (!rst_n)
        commit_done_reg |-> (q_valid && q_job.has_commit))
        else $error("commit marked done with no matching head job");

    a_partial_keeps_head: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !cur_last) |=> (q_valid && out_valid_reg && !out_last_reg))
        else $error("job left the queue before its last result");

    a_ok_only_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ok_reg) |-> (out_kind_reg == fprc_pkg::KIND_ACK && out_last_reg))
        else $error("image ok flag on a result other than the closing ack");

endmodule

`default_nettype wire

// ----- hdl/firmware_page_receiver_crc32.sv -----
// Top level of the firmware page receiver with CRC-32 check.
//
//  channel     | direction | transaction
//  s_axis      | in        | one item: tuser = mode, tdata = kind, byte, sender CRC, CRC flag
//  m_axis      | out       | one result: tuser = kind, tdata = address, byte, image ok
//  cfg_wr      | in        | download base address, written when idle
//
//  One item is taken per cycle while the job queue has room; the front updates
//  CRC, counters and page address in the accepting cycle.
//  The back emits one result per cycle while the output is not stalled: one result for
//  most items, two for a byte that closes a packet or an end item with a pending page,
//  three for a byte that closes a full page, none for a byte with no valid packet size.
//  Results pass through the job queue and the output register.
//  Either side may stall; the queue of QUEUE_DEPTH jobs decouples them.
//  Reset clears all control state; the page address restarts at zero.
`default_nettype none

module firmware_page_receiver_crc32 #(
    parameter int PAGE_BYTES  = 2048,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // packet_kind[7:0], data_byte[15:8],
                                             // sender_crc[47:16], crc_present[48]
    input  wire logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // flash_address[31:0], byte_value[39:32],
                                             // image_ok[40]
    output logic [1:0]       m_axis_tuser,   // result_kind[1:0]
    output logic             m_axis_tlast
);

    fprc_pkg::job_t front_job;
    fprc_pkg::job_t head_job;
    logic           front_push;
    logic           head_valid;
    logic           head_pop;
    logic [31:0]    out_addr;
    logic [7:0]     out_byte;
    logic           out_ok;

    fprc_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .mode        (s_axis_tuser),
        .packet_kind (s_axis_tdata[7:0]),
        .data_byte   (s_axis_tdata[15:8]),
        .sender_crc  (s_axis_tdata[47:16]),
        .crc_present (s_axis_tdata[48]),
        .push        (front_push),
        .job         (front_job)
    );

    fprc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_job   (front_job),
        .not_full   (s_axis_tready),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    fprc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (head_valid),
        .q_job     (head_job),
        .q_pop     (head_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_addr  (out_addr),
        .out_byte  (out_byte),
        .out_ok    (out_ok),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, out_ok, out_byte, out_addr};

endmodule

`default_nettype wire

// ----- bench/fprc_checker.sv -----
// Checker for the firmware page receiver: predicts every result and compares the output stream.
`timescale 1ns / 1ps

module fprc_checker #(
    parameter int PAGE_BYTES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          outstanding,
    output int          stores_seen,
    output int          commits_seen,
    output int          image_ok_seen,
    output int          naks_seen
);

    localparam logic [31:0] REFLECTED_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [7:0]  value;
        logic        ok;
        logic        last;
    } flash_op_t;

    flash_op_t   expected_ops[$];
    logic [31:0] base_addr;
    logic [31:0] crc_acc;
    logic [31:0] held_crc;
    logic [31:0] page_addr;
    logic [1:0]  size_sel;
    int          byte_count;
    int          packet_count;
    int          mismatches;

    assign fail_count = mismatches;

    function automatic logic [31:0] crc32_fold(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc ^ {24'h0, b};
        repeat (8)
        begin
            r = r[0] ? ({1'b0, r[31:1]} ^ REFLECTED_POLY) : {1'b0, r[31:1]};
        end
        return r;
    endfunction

    function automatic flash_op_t make_op(input logic [1:0] kind, input logic [31:0] addr,
                                          input logic [7:0] value, input logic ok,
                                          input logic last);
        flash_op_t op;
        op.kind  = kind;
        op.addr  = addr;
        op.value = value;
        op.ok    = ok;
        op.last  = last;
        return op;
    endfunction

    // Works out the results of one accepted item and queues them in order.
    task automatic predict_item(input logic [1:0] mode, input logic [7:0] pkt_kind,
                                input logic [7:0] value, input logic [31:0] sender_crc,
                                input logic crc_flag);
        flash_op_t   ops [0:2];
        int          n;
        int          size;
        int          per_page;
        logic [31:0] offset;
        logic [31:0] fin;
        n = 0;
        case (mode)
            fprc_pkg::MODE_START:
            begin
                if (pkt_kind == fprc_pkg::PKT_KIND_LARGE)
                    size_sel = fprc_pkg::SEL_LARGE;
                else if (pkt_kind == fprc_pkg::PKT_KIND_SMALL)
                    size_sel = fprc_pkg::SEL_SMALL;
                else
                    size_sel = fprc_pkg::SEL_INVALID;
                crc_acc    = CRC_PRESET;
                byte_count = 0;
                ops[n] = make_op(fprc_pkg::KIND_ACK, 32'h0, 8'h0, 1'b0, 1'b0);
                n++;
            end
            fprc_pkg::MODE_DATA:
            begin
                if (size_sel == fprc_pkg::SEL_LARGE || size_sel == fprc_pkg::SEL_SMALL)
                begin
                    size     = (size_sel == fprc_pkg::SEL_LARGE) ? 1024 : 128;
                    per_page = PAGE_BYTES / size;
                    if (per_page == 0)
                        per_page = 1;
                    offset = packet_count * size + byte_count;
                    ops[n] = make_op(fprc_pkg::KIND_STORE, page_addr + offset, value,
                                     1'b0, 1'b0);
                    n++;
                    crc_acc = crc32_fold(crc_acc, value);
                    byte_count++;
                    if (byte_count >= size)
                    begin
                        byte_count = 0;
                        packet_count++;
                        // "at least": a size change mid-page can leave more packets than needed
                        if (packet_count >= per_page)
                        begin
                            ops[n] = make_op(fprc_pkg::KIND_COMMIT, page_addr, 8'h0, 1'b0, 1'b0);
                            n++;
                            page_addr    = page_addr + PAGE_BYTES;
                            packet_count = 0;
                        end
                        ops[n] = make_op(fprc_pkg::KIND_ACK, 32'h0, 8'h0, 1'b0, 1'b0);
                        n++;
                    end
                end
            end
            fprc_pkg::MODE_END:
            begin
                if (crc_flag)
                    held_crc = sender_crc;
                if (packet_count != 0 || byte_count != 0)
                begin
                    ops[n] = make_op(fprc_pkg::KIND_COMMIT, page_addr, 8'h0, 1'b0, 1'b0);
                    n++;
                end
                packet_count = 0;
                byte_count   = 0;
                page_addr    = base_addr;
                fin = crc_acc ^ CRC_PRESET;
                if (fin == held_crc)
                begin
                    crc_acc = fin;
                    ops[n] = make_op(fprc_pkg::KIND_ACK, 32'h0, 8'h0, 1'b1, 1'b0);
                end
                else
                begin
                    ops[n] = make_op(fprc_pkg::KIND_NAK, 32'h0, 8'h0, 1'b0, 1'b0);
                end
                n++;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            ops[i].last = (i == n - 1);
            expected_ops.push_back(ops[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        flash_op_t want;
        flash_op_t got;
        if (!rst_n)
        begin
            expected_ops.delete();
            base_addr     = 32'h0;
            crc_acc       = CRC_PRESET;
            held_crc      = 32'h0;
            page_addr     = 32'h0;
            size_sel      = fprc_pkg::SEL_INVALID;
            byte_count    = 0;
            packet_count  = 0;
            mismatches    = 0;
            stores_seen   = 0;
            commits_seen  = 0;
            image_ok_seen = 0;
            naks_seen     = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                base_addr = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                             s_axis_tdata[47:16], s_axis_tdata[48]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = make_op(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32],
                              m_axis_tdata[40], m_axis_tlast);
                case (got.kind)
                    fprc_pkg::KIND_STORE:  stores_seen++;
                    fprc_pkg::KIND_COMMIT: commits_seen++;
                    fprc_pkg::KIND_NAK:    naks_seen++;
                    default:               image_ok_seen += got.ok;
                endcase
                if (expected_ops.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with none expected, got kind %0d addr %h",
                                 $time, got.kind, got.addr);
                end
                else
                begin
                    want = expected_ops.pop_front();
                    check_field("result_kind", want.kind, got.kind);
                    check_field("flash_address", want.addr, got.addr);
                    check_field("byte_value", want.value, got.value);
                    check_field("image_ok", want.ok, got.ok);
                    check_field("last_result", want.last, got.last);
                end
            end
            outstanding <= expected_ops.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Top of the bench: clock, reset, stimulus, result sink and verdict for the firmware page receiver.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         LONG_HOLD   = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // packet_kind[7:0], data_byte[15:8], sender_crc[47:16],
                                 // crc_present[48]
    logic [1:0]  s_axis_tuser;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // flash_address[31:0], byte_value[39:32], image_ok[40]
    logic [1:0]  m_axis_tuser;   // result_kind[1:0]
    logic        m_axis_tlast;

    int fail_count;
    int outstanding;
    int stores_seen;
    int commits_seen;
    int image_ok_seen;
    int naks_seen;

    int          items_sent;
    int          holds_wanted;
    int          holds_done;
    bit          steady;
    bit          tx_sized;
    logic [31:0] tx_crc;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    firmware_page_receiver_crc32 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    fprc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .stores_seen   (stores_seen),
        .commits_seen  (commits_seen),
        .image_ok_seen (image_ok_seen),
        .naks_seen     (naks_seen)
    );

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result sink: random stalls per transaction unless steady, one long hold-off on request
    initial
    begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (holds_wanted != holds_done)
            begin
                holds_done++;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // offers one item and returns at the edge that accepts it, tvalid still high
    task automatic offer(input logic [1:0] mode, input logic [7:0] pkt_kind,
                         input logic [7:0] value, input logic [31:0] sender_crc,
                         input logic crc_flag);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'd0, crc_flag, sender_crc, value, pkt_kind};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        // sender side CRC, used only to build end items
        if (mode == fprc_pkg::MODE_START)
        begin
            tx_sized = (pkt_kind == fprc_pkg::PKT_KIND_LARGE) ||
                       (pkt_kind == fprc_pkg::PKT_KIND_SMALL);
            tx_crc   = fprc_pkg::CRC_INIT;
        end
        else if (mode == fprc_pkg::MODE_DATA && tx_sized)
        begin
            tx_crc = fprc_pkg::crc_byte(tx_crc, value);
        end
    endtask

    task automatic send_start(input logic [7:0] pkt_kind);
        offer(fprc_pkg::MODE_START, pkt_kind, 8'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] value);
        offer(fprc_pkg::MODE_DATA, 8'($urandom), value, $urandom, 1'($urandom));
    endtask

    task automatic send_end(input logic [31:0] sender_crc, input logic crc_flag);
        offer(fprc_pkg::MODE_END, 8'($urandom), 8'($urandom), sender_crc, crc_flag);
    endtask

    task automatic send_bytes(input int count);
        repeat (count) send_byte(8'($urandom));
    endtask

    // mostly a correct CRC, sometimes a wrong one or none at all
    task automatic finish_transfer();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            send_end(tx_crc ^ 32'hFFFF_FFFF, 1'b1);
        else if (pick < 9)
            send_end($urandom, 1'b1);
        else
            send_end($urandom, 1'b0);
    endtask

    task automatic short_transfer();
        int pick;
        int count;
        pick = $urandom_range(0, 19);
        if (pick < 13)
            send_start(fprc_pkg::PKT_KIND_SMALL);
        else if (pick < 17)
            send_start(fprc_pkg::PKT_KIND_LARGE);
        else
            send_start(8'($urandom_range(2, 255)));
        count = $urandom_range(0, 12);
        repeat (count)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                offer(MODE_UNUSED, 8'($urandom), 8'($urandom), $urandom, 1'($urandom));
            else if (pick == 1)
                send_start(8'($urandom_range(0, 3)));
            send_byte(8'($urandom));
        end
        finish_transfer();
    endtask

    // waits until every expected result is in and the block has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_base(input logic [31:0] addr);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 32'h0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 56'h0;
        s_axis_tuser  = fprc_pkg::MODE_START;
        items_sent    = 0;
        holds_wanted  = 0;
        holds_done    = 0;
        steady        = 1'b0;
        tx_sized      = 1'b0;
        tx_crc        = fprc_pkg::CRC_INIT;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_base(32'h0000_0000);
        send_byte(8'h5A);                       // no packet size yet: dropped
        offer(MODE_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_start(8'd2);                       // invalid kind, byte dropped
        send_byte(8'hFF);
        send_start(8'hFF);
        send_start(fprc_pkg::PKT_KIND_LARGE);
        send_end(32'h0000_0000, 1'b1);          // empty image, finalised CRC is zero
        send_end(32'hFFFF_FFFF, 1'b1);          // second end matches the kept value
        send_end(32'h0000_0000, 1'b0);          // held value kept, now a mismatch
        send_start(fprc_pkg::PKT_KIND_SMALL);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_end(tx_crc ^ 32'hFFFF_FFFF, 1'b1); // partial page flushed, image ok
        send_start(fprc_pkg::PKT_KIND_LARGE);
        send_byte(8'h80);
        send_byte(8'h01);
        send_end(tx_crc, 1'b1);                 // wrong CRC: flush then nak

        set_base($urandom);
        short_transfer();
        // one whole small packet and one byte of the next, results held off for a long stretch half way through
        send_start(fprc_pkg::PKT_KIND_SMALL);
        send_bytes(64);
        holds_wanted++;
        send_bytes(64 + 1);
        finish_transfer();

        set_base(32'hFFFF_FFFF);
        short_transfer();                       // its end rewinds to the top address
        steady = 1'b1;
        short_transfer();                       // stores wrap past zero
        steady = 1'b0;

        drain();
        $display("Sent %0d items over three base addresses (lowest and highest included).",
                 items_sent);
        $display("Seen %0d stores, %0d page commits, %0d image-ok acks, %0d naks.",
                 stores_seen, commits_seen, image_ok_seen, naks_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
